// ----- sv/otsb_pkg.sv -----
// shared types, constants and command codes for the one-shot timer bank
package otsb_pkg;

   localparam int NUM_TIMERS = 10;
   localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int MASK_W     = 10;
   localparam int NEW_ID_W   = 4;
   localparam int CMP_W      = 8;
   localparam int PER_W      = 8;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [5:0]       slot_id;
      logic [PER_W-1:0] period;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [NEW_ID_W-1:0] new_id;
      logic [MASK_W-1:0]   expired_mask;
   } rsp_type;

   typedef struct packed {
      logic             active;
      logic [PER_W-1:0] count;
      logic [PER_W-1:0] period;
   } slot_type;

   typedef struct packed {
      req_type word;
      logic    slot_allocated;
   } walk_ctl_type;

endpackage

// ----- sv/one_shot_timer_bank_top.sv -----
// top level of the one-shot timer bank: command control and the ring of slot cells
// flow: a word accepted while idle walks the ring, which makes one full turn, one slot
//   per cycle; the registered result strobe follows the last slot of the turn
// one word at a time: no new word is taken until the turn is done, as set by the single update
//   point at the head of the ring; busy stays high while the ring turns
// reset: synchronous, active high; all slots inactive with zero counter and
//   period, no slots allocated; the receiver cannot stall, results are one-cycle strobes
module one_shot_timer_bank_top
   import otsb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   // controller states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                state_ff, state_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]    alloc_ff, alloc_in;
   req_type             word_ff, word_in;
   logic                status_ff, status_in;
   logic [NEW_ID_W-1:0] new_id_ff, new_id_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic          accept;
   logic          shift_en;
   logic          last_slot;
   logic          id_ok;
   walk_ctl_type  ctl;
   slot_type      cell_q [NUM_TIMERS];
   slot_type      head_nxt;
   logic          expire;

   assign accept    = start && (state_ff == ST_IDLE);
   assign shift_en  = state_ff == ST_WALK;
   assign last_slot = pos_ff == SLOT_W'(NUM_TIMERS - 1);
   assign id_ok     = CMP_W'(req_word.slot_id) < CMP_W'(NUM_TIMERS);

   // ring: head cell feeds the update, result re-enters at the tail
   assign ctl.word           = word_ff;
   assign ctl.slot_allocated = CMP_W'(pos_ff) < CMP_W'(alloc_ff);

   otsb_update u_update (
      .ctl    (ctl),
      .pos    (pos_ff),
      .cur    (cell_q[0]),
      .nxt    (head_nxt),
      .expire (expire)
   );

   for (genvar gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      slot_type from_next;
      if (gi == NUM_TIMERS - 1) begin : g_tail
         assign from_next = head_nxt;
      end else begin : g_mid
         assign from_next = cell_q[gi+1];
      end
      otsb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .from_next (from_next),
         .q         (cell_q[gi])
      );
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      alloc_in     = alloc_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      new_id_in    = new_id_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // allocate and id checks are settled up front
               word_in   = req_word;
               pos_in    = '0;
               mask_in   = '0;
               status_in = 1'b0;
               new_id_in = '0;
               state_in  = ST_WALK;
               if (req_word.cmd == CMD_ALLOC) begin
                  if (CMP_W'(alloc_ff) < CMP_W'(NUM_TIMERS)) begin
                     new_id_in = NEW_ID_W'(alloc_ff);
                     alloc_in  = alloc_ff + CNT_W'(1);
                  end else begin
                     new_id_in = NEW_ID_W'(NUM_TIMERS);
                     status_in = 1'b1;
                  end
               end else if (req_word.cmd == CMD_START || req_word.cmd == CMD_STOP) begin
                  status_in = !id_ok;
               end
            end
         end
         ST_WALK: begin
            // collect expiry bits for slots that fit in the mask
            for (int b = 0; b < MASK_W; b++) begin
               if (expire && (CMP_W'(pos_ff) == CMP_W'(b))) begin
                  mask_in[b] = 1'b1;
               end
            end
            pos_in = pos_ff + SLOT_W'(1);
            if (last_slot) begin
               pos_in       = '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      status_ff <= status_in;
      new_id_ff <= new_id_in;
      mask_ff   <= mask_in;
   end

   assign busy                  = state_ff == ST_WALK;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_word.status       = status_ff;
   assign rsp_word.new_id       = new_id_ff;
   assign rsp_word.expired_mask = mask_ff;

endmodule

// ----- sv/otsb_cell.sv -----
// one cell of the slot ring: holds one slot and takes its neighbor's slot on a shift
module otsb_cell
   import otsb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  slot_type from_next,
   output slot_type q
);

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift_en) begin
         slot_ff <= from_next;
      end
   end

   assign q = slot_ff;

endmodule

// ----- sv/otsb_update.sv -----
// command update applied to the slot leaving the head of the ring
module otsb_update
   import otsb_pkg::*;
(
   input  walk_ctl_type     ctl,
   input  logic [SLOT_W-1:0] pos,
   input  slot_type         cur,
   output slot_type         nxt,
   output logic             expire
);

   logic             hit;
   logic [PER_W-1:0] cnt_inc;

   assign hit     = CMP_W'(pos) == CMP_W'(ctl.word.slot_id);
   assign cnt_inc = cur.count + PER_W'(1);

   always_comb begin
      nxt    = cur;
      expire = 1'b0;
      unique case (ctl.word.cmd)
         CMD_ALLOC: begin
            nxt = cur;
         end
         CMD_START: begin
            if (hit) begin
               nxt.period = ctl.word.period;
               nxt.count  = '0;
               nxt.active = 1'b1;
            end
         end
         CMD_STOP: begin
            if (hit) begin
               nxt.count  = '0;
               nxt.active = 1'b0;
            end
         end
         CMD_TICK: begin
            if (ctl.slot_allocated && cur.active) begin
               nxt.count = cnt_inc;
               if (cnt_inc == cur.period) begin
                  nxt.active = 1'b0;
                  expire     = 1'b1;
               end
            end
         end
      endcase
   end

endmodule

// ----- tb/one_shot_timer_bank_top_tb.sv -----
// self-checking testbench for the one-shot timer bank top level
`timescale 1ns / 1ps

module one_shot_timer_bank_top_tb;
   import otsb_pkg::*;

   // a queued command word, optionally held back until the bank has drained
   typedef struct {
      req_type word;
      bit      drain;
   } cmd_entry_type;

   // clock and reset; every input known from time zero
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   one_shot_timer_bank_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // command words still to send, and results the bank owes us
   cmd_entry_type cmd_pending_q[$];
   rsp_type       rsp_expected_q[$];

   // shadow copy of the timer bank
   bit               slot_active [NUM_TIMERS];
   logic [PER_W-1:0] slot_count  [NUM_TIMERS];
   logic [PER_W-1:0] slot_period [NUM_TIMERS];
   int               slots_handed = 0;

   // bookkeeping
   int  mismatches      = 0;
   int  words_accepted  = 0;
   int  results_checked = 0;
   int  ticks_sent      = 0;
   int  expiries_due    = 0;
   int  errors_due      = 0;
   bit  bank_drained    = 1'b1;
   int  burst_left      = 0;
   int  gap_left        = 0;

   initial begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         slot_active[i] = 1'b0;
         slot_count[i]  = '0;
         slot_period[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 30)
         $display("%0t ns  mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // advance the shadow bank by one command and queue the result it owes
   task automatic timer_bank_step(input req_type w);
      rsp_type r;
      r = '0;
      case (w.cmd)
         CMD_ALLOC: begin
            if (slots_handed < NUM_TIMERS) begin
               r.new_id = NEW_ID_W'(slots_handed);
               slots_handed++;
            end else begin
               // bank full: slot count comes back with an error
               r.new_id = NEW_ID_W'(NUM_TIMERS);
               r.status = 1'b1;
            end
         end
         CMD_START: begin
            if (int'(w.slot_id) < NUM_TIMERS) begin
               // also legal on a slot not yet handed out; restart reloads
               slot_period[w.slot_id] = w.period;
               slot_count[w.slot_id]  = '0;
               slot_active[w.slot_id] = 1'b1;
            end else begin
               r.status = 1'b1;
            end
         end
         CMD_STOP: begin
            if (int'(w.slot_id) < NUM_TIMERS) begin
               slot_count[w.slot_id]  = '0;
               slot_active[w.slot_id] = 1'b0;
            end else begin
               r.status = 1'b1;
            end
         end
         CMD_TICK: begin
            ticks_sent++;
            // only handed-out slots count; period zero wraps to 256 ticks
            for (int i = 0; i < slots_handed && i < NUM_TIMERS; i++) begin
               if (slot_active[i]) begin
                  slot_count[i] = slot_count[i] + 1'b1;
                  if (slot_count[i] == slot_period[i]) begin
                     slot_active[i] = 1'b0;
                     if (i < MASK_W) begin
                        r.expired_mask[i] = 1'b1;
                        expiries_due++;
                     end
                  end
               end
            end
         end
      endcase
      if (r.status)
         errors_due++;
      rsp_expected_q.push_back(r);
   endtask

   // stimulus helpers
   task automatic queue_word(input logic [1:0] cmd, input int id, input int per,
                             input bit drain = 1'b0);
      cmd_entry_type e;
      e.word.cmd     = cmd;
      e.word.slot_id = 6'(id);
      e.word.period  = PER_W'(per);
      e.drain        = drain;
      cmd_pending_q.push_back(e);
   endtask

   // mostly a real slot, now and then an id past the end of the bank
   function automatic int pick_slot();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(NUM_TIMERS, 63);
      return $urandom_range(0, NUM_TIMERS - 1);
   endfunction

   // short periods so expiries show up often, full range otherwise
   function automatic int pick_period();
      if ($urandom_range(0, 9) < 7)
         return $urandom_range(1, 24);
      return $urandom_range(0, 255);
   endfunction

   // we sample the expected store at the falling edge so the driver reads a
   // settled value at the rising edge
   always @(negedge clock) begin
      bank_drained <= (rsp_expected_q.size() == 0);
   end

   // driver: presents the oldest pending word, bursts with random gaps between
   always @(posedge clock) begin : drv
      bit took;
      took = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         // start high with busy low at this edge: the word went in
         if (start) begin
            took = 1'b1;
            timer_bank_step(req_word);
            void'(cmd_pending_q.pop_front());
            words_accepted++;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               case ($urandom_range(0, 7))
                  0: begin
                     // long stretch with no idling
                     burst_left = 40;
                     gap_left   = 0;
                  end
                  1, 2: begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 3);
                  end
                  default: begin
                     // random gaps land on every phase of the ring turn
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(1, 25);
                  end
               endcase
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_pending_q.size() != 0 &&
                      !(cmd_pending_q[0].drain && (took || !bank_drained))) begin
            start    <= 1'b1;
            req_word <= cmd_pending_q[0].word;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each strobed result is matched against the oldest expectation
   always @(posedge clock) begin : mon
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (rsp_expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_word));
         end else begin
            want = rsp_expected_q.pop_front();
            results_checked++;
            if (rsp_word.status !== want.status)
               report_mismatch($sformatf("result %0d status %b, want %b",
                  results_checked, rsp_word.status, want.status));
            if (rsp_word.new_id !== want.new_id)
               report_mismatch($sformatf("result %0d new_id %0d, want %0d",
                  results_checked, rsp_word.new_id, want.new_id));
            if (rsp_word.expired_mask !== want.expired_mask)
               report_mismatch($sformatf("result %0d expired_mask %b, want %b",
                  results_checked, rsp_word.expired_mask, want.expired_mask));
         end
      end
   end

   // stimulus, reset and end of run
   initial begin : stim
      int  random_words;
      bit  soak_done;
      int  n;
      random_words = 0;
      soak_done    = 1'b0;

      // directed part
      queue_word(CMD_TICK,  0, 0);        // tick with nothing handed out
      queue_word(CMD_START, 0, 1);        // start on a slot not yet handed out
      queue_word(CMD_TICK,  0, 0);        // such a slot must not count
      queue_word(CMD_ALLOC, 0, 0);        // first slot, id 0
      queue_word(CMD_TICK,  0, 0);        // slot 0 now counts and expires
      queue_word(CMD_ALLOC, 0, 0);
      queue_word(CMD_START, 1, 2);
      queue_word(CMD_START, 0, 255);      // largest period
      queue_word(CMD_TICK,  0, 0);
      queue_word(CMD_START, 1, 2);        // restart while active clears count
      queue_word(CMD_TICK,  0, 0);
      queue_word(CMD_TICK,  0, 0);        // slot 1 expires here
      queue_word(CMD_STOP,  0, 0);
      queue_word(CMD_START, NUM_TIMERS, 8'hAA);  // first bad id
      queue_word(CMD_STOP,  63, 0);              // highest bad id
      queue_word(CMD_START, 63, 8'h55);
      queue_word(CMD_START, 1, 0);        // period zero means 256 ticks
      for (int i = 2; i < NUM_TIMERS; i++)
         queue_word(CMD_ALLOC, 0, 0);     // fill the bank
      queue_word(CMD_ALLOC, 0, 0);        // bank full

      // random part, made of episodes; the first word waits for a drained bank
      queue_word(CMD_TICK, 0, 0, 1'b1);
      while (random_words < 520) begin
         if (!soak_done && random_words > 150) begin
            // long soak: periods zero, 255 and 128 all run out
            soak_done = 1'b1;
            queue_word(CMD_START, 4, 0);
            queue_word(CMD_START, 5, 255);
            queue_word(CMD_START, 6, 128);
            for (int i = 0; i < 257; i++)
               queue_word(CMD_TICK, 0, 0);
            random_words += 260;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // arm a few slots, then run the clock with the odd stop or restart
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++)
                  queue_word(CMD_START, pick_slot(), pick_period());
               random_words += n;
               n = $urandom_range(1, 30);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 9) == 0)
                     queue_word(CMD_STOP, pick_slot(), $urandom_range(0, 255));
                  else if ($urandom_range(0, 9) == 0)
                     queue_word(CMD_START, pick_slot(), pick_period());
                  else
                     queue_word(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 255));
               end
               random_words += n;
            end
            6, 7: begin
               // noise over every field
               n = $urandom_range(3, 10);
               for (int i = 0; i < n; i++)
                  queue_word(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 255));
               random_words += n;
            end
            8: begin
               // stop sweep, some of them on ids past the end
               n = $urandom_range(1, 5);
               for (int i = 0; i < n; i++)
                  queue_word(CMD_STOP, pick_slot(), $urandom_range(0, 255));
               random_words += n;
            end
            default: begin
               // hold the sender until every owed result is back
               queue_word(CMD_START, pick_slot(), pick_period(), 1'b1);
               random_words++;
            end
         endcase
      end

      // hold reset at the start, then release it and let the driver run
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (cmd_pending_q.size() != 0 || rsp_expected_q.size() != 0)
         @(negedge clock);
      // keep running past the last result to catch a stray strobe
      repeat (NUM_TIMERS + 4) @(negedge clock);

      if (rsp_expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", rsp_expected_q.size()));

      $display("sent %0d words (%0d ticks), checked %0d results", words_accepted,
               ticks_sent, results_checked);
      $display("saw %0d slot expiries and %0d error replies, %0d mismatches",
               expiries_due, errors_due, mismatches);
      if (mismatches == 0) begin
         $display("one_shot_timer_bank_top regression: pass");
      end else begin
         $display("one_shot_timer_bank_top regression: fail");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout after %0t ns", $time);
      $display("one_shot_timer_bank_top regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/otsb_pkg.sv
sv/otsb_cell.sv
sv/otsb_update.sv
sv/one_shot_timer_bank_top.sv
tb/one_shot_timer_bank_top_tb.sv
